>>> hw/rtl/dbcf_pkg.sv
// ============================================================================
// dbcf_pkg
// Shared constants and codes for the depth boundary correspondence filter.
// ============================================================================
`default_nettype none

package dbcf_pkg;

  // Store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_WINDOW = 15;

  // Field widths
  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH_W = 16;
  localparam int QIDX_W  = 20;
  localparam int COUNT_W = 8;
  localparam int WIDTH_W = 11;
  localparam int HGT_W   = 10;
  localparam int WIN_W   = 4;
  localparam int STEP_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_WINDOW_SIZE  = 3'd2,
    CFG_COUNT_LIMIT  = 3'd3,
    CFG_STEP_LIMIT   = 3'd4
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [WIDTH_W-1:0] RST_WIDTH  = WIDTH_W'(640);
  localparam logic [HGT_W-1:0]   RST_HEIGHT = HGT_W'(480);
  localparam logic [WIN_W-1:0]   RST_WINDOW = WIN_W'(5);
  localparam logic [COUNT_W-1:0] RST_LIMIT  = COUNT_W'(8);
  localparam logic [STEP_W-1:0]  RST_STEP   = STEP_W'(25);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage

`default_nettype wire

>>> hw/rtl/dbcf_in_if.sv
// ============================================================================
// dbcf_in_if
// Input channel: pixel write or correspondence query word.
// ============================================================================
`default_nettype none

interface dbcf_in_if;
  import dbcf_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [ADDR_W-1:0]   pixel_address;
  logic [DEPTH_W-1:0]  depth_mm;
  logic                depth_valid;
  logic [QIDX_W-1:0]   query_index;
  logic [ADDR_W-1:0]   match_index;

  modport source (
    output valid, operation, pixel_address, depth_mm, depth_valid,
           query_index, match_index,
    input  ready
  );

  modport sink (
    input  valid, operation, pixel_address, depth_mm, depth_valid,
           query_index, match_index,
    output ready
  );

endinterface

`default_nettype wire

>>> hw/rtl/dbcf_out_if.sv
// ============================================================================
// dbcf_out_if
// Result channel: one verdict word per query.
// ============================================================================
`default_nettype none

interface dbcf_out_if;
  import dbcf_pkg::*;

  logic                valid;
  logic                ready;
  logic [QIDX_W-1:0]   query_index_out;
  logic [ADDR_W-1:0]   match_index_out;
  logic                kept;
  logic [COUNT_W-1:0]  boundary_count;

  modport source (
    output valid, query_index_out, match_index_out, kept, boundary_count,
    input  ready
  );

  modport sink (
    input  valid, query_index_out, match_index_out, kept, boundary_count,
    output ready
  );

endinterface

`default_nettype wire

>>> hw/rtl/depth_boundary_correspondence_filter_top.sv
// ============================================================================
// depth_boundary_correspondence_filter_top
// Depth image store with a window walker that rejects correspondences
// whose matched pixel sits on a depth boundary.
// ============================================================================
//
//  channel | dir | handshake      | word
//  --------+-----+----------------+-----------------------------------------
//  in_if   | in  | valid / ready  | op, pixel addr, depth, valid, qidx, midx
//  out_if  | out | valid / ready  | qidx, midx, kept, boundary count
//  cfg_*   | in  | cfg_we only    | register index, data (no read-back)
//
//  A pixel write goes to the depth memory on accept; in_if.ready stays high
//  in idle. A query that passes the geometry and index range checks steps
//  an N x N window, N = 2*(window_size/2) + 1 (1 for size 0); the clipped
//  window is still stepped in full. Every query first runs the 19-step
//  restoring divider (index -> row, col), then the walk reads the
//  single-port depth memory, one pixel per cycle.
//  Reset is synchronous, active low, and clears control state only; the
//  depth memory has no clearing pass. The result register lets the next
//  word be accepted while a verdict waits on out_if.ready; a query that
//  finishes meanwhile holds in its last state until that verdict is taken.
// ============================================================================
`default_nettype none

module depth_boundary_correspondence_filter_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  dbcf_in_if.sink                           in_if,
  dbcf_out_if.source                        out_if,
  input  wire logic                         cfg_we,
  input  wire logic [dbcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dbcf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dbcf_pkg::*;

  // Derived sizes
  localparam int STORE_W = DEPTH_W + 1;              // valid + depth
  localparam int HALF_W  = $clog2(MAX_WINDOW / 2 + 1);
  localparam int DOFF_W  = HALF_W + 1;               // signed window offset
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int XS_W    = WIDTH_W + 2;              // signed column
  localparam int YS_W    = ROW_W + 2;                // signed row
  localparam int AS_W    = ADDR_W + 2;               // signed linear address
  localparam int HW_W    = HALF_W + WIDTH_W;
  localparam int DCNT_W  = $clog2(ADDR_W);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(ADDR_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_CREAD,
    ST_CLATCH,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WIDTH_W-1:0] width_r;
  logic [HGT_W-1:0]   height_r;
  logic [WIN_W-1:0]   window_r;
  logic [COUNT_W-1:0] limit_r;
  logic [STEP_W-1:0]  step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      window_r <= RST_WINDOW;
      limit_r  <= RST_LIMIT;
      step_r   <= RST_STEP;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        CFG_WINDOW_SIZE:  window_r <= cfg_data[WIN_W-1:0];
        CFG_COUNT_LIMIT:  limit_r  <= cfg_data[COUNT_W-1:0];
        CFG_STEP_LIMIT:   step_r   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  state_t                    state_r;
  logic [QIDX_W-1:0]         qi_r;
  logic [ADDR_W-1:0]         mi_r;
  logic [ADDR_W-1:0]         div_r;      // dividend, shifts into quotient (row)
  logic [WIDTH_W-1:0]        rem_r;      // remainder (column)
  logic [DCNT_W-1:0]         div_cnt_r;
  logic                      bad_r;      // geometry makes any query reject
  logic                      reject_r;
  logic signed [AS_W-1:0]    row_addr_r;
  logic signed [AS_W-1:0]    addr_r;
  logic signed [DOFF_W-1:0]  dx_r;
  logic signed [DOFF_W-1:0]  dy_r;
  logic [STORE_W-1:0]        centre_r;
  logic                      pend_r;     // mem_q_r holds a window pixel
  logic [COUNT_W-1:0]        count_r;

  logic                      out_valid_r;
  logic [QIDX_W-1:0]         out_qi_r;
  logic [ADDR_W-1:0]         out_mi_r;
  logic                      out_kept_r;
  logic [COUNT_W-1:0]        out_count_r;

  // --------------------------------------------------------------------------
  // Depth memory: one port, registered read
  // --------------------------------------------------------------------------
  logic [STORE_W-1:0] depth_mem [MAX_WIDTH * MAX_HEIGHT];
  logic [STORE_W-1:0] mem_q_r;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  // --------------------------------------------------------------------------
  // Window geometry
  // --------------------------------------------------------------------------
  logic [WIN_W-1:0]          win_clamp;
  logic [HALF_W-1:0]         half;
  logic signed [DOFF_W-1:0]  half_pos;
  logic signed [DOFF_W-1:0]  half_neg;
  logic [HW_W-1:0]           half_times_w;
  logic signed [AS_W-1:0]    start_addr;
  logic signed [XS_W-1:0]    xs;
  logic signed [YS_W-1:0]    ys;
  logic                      in_win;
  logic                      last_px;

  assign win_clamp = (window_r > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_r;
  assign half      = HALF_W'(win_clamp >> 1);
  assign half_pos  = $signed({1'b0, half});
  assign half_neg  = -half_pos;
  assign half_times_w = HW_W'(half) * HW_W'(width_r);
  assign start_addr   = $signed({2'b00, mi_r})
                      - $signed(AS_W'(half_times_w))
                      - $signed(AS_W'(half));

  assign xs = $signed({2'b00, rem_r}) + XS_W'(dx_r);
  assign ys = $signed({2'b00, div_r[ROW_W-1:0]}) + YS_W'(dy_r);
  assign in_win = (xs >= 0) && (xs < $signed({2'b00, width_r})) &&
                  (ys >= 0) && (ys < $signed(YS_W'(height_r)));
  assign last_px = (dx_r == half_pos) && (dy_r == half_pos);

  // --------------------------------------------------------------------------
  // Divider step: restoring, one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [WIDTH_W:0] rem_sh;
  logic             div_ge;
  assign rem_sh = {rem_r, div_r[ADDR_W-1]};
  assign div_ge = rem_sh >= {1'b0, width_r};

  // --------------------------------------------------------------------------
  // Neighbor test on the word just read
  // --------------------------------------------------------------------------
  logic [DEPTH_W-1:0] nd;
  logic [DEPTH_W-1:0] cd;
  logic [DEPTH_W-1:0] diff;
  logic               hit;
  assign nd   = mem_q_r[DEPTH_W-1:0];
  assign cd   = centre_r[DEPTH_W-1:0];
  assign diff = (nd > cd) ? (nd - cd) : (cd - nd);
  // invalid neighbor always counts; a step counts only with a valid center
  assign hit  = !mem_q_r[DEPTH_W] || (centre_r[DEPTH_W] && (diff > step_r));

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_acc;
  logic bad_geom;
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign bad_geom    = (height_r <= HGT_W'(1)) || (width_r == '0) ||
                       (width_r > WIDTH_W'(MAX_WIDTH)) ||
                       (height_r > HGT_W'(MAX_HEIGHT));

  assign mem_we    = in_acc && (op_t'(in_if.operation) == OP_WRITE);
  assign mem_re    = (state_r == ST_CREAD) || ((state_r == ST_WALK) && in_win);
  assign mem_raddr = (state_r == ST_CREAD) ? mi_r : addr_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[in_if.pixel_address] <= {in_if.depth_valid, in_if.depth_mm};
    end else if (mem_re) begin
      mem_q_r <= depth_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and result register
  // --------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      div_cnt_r   <= '0;
      reject_r    <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      // ST_DONE reloads the result register itself
      if (out_valid_r && out_if.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      pend_r <= (state_r == ST_WALK) && in_win;
      if (pend_r && hit && (count_r != '1)) begin
        count_r <= count_r + COUNT_W'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (op_t'(in_if.operation) == OP_QUERY)) begin
            qi_r      <= in_if.query_index;
            mi_r      <= in_if.match_index;
            div_r     <= in_if.match_index;
            rem_r     <= '0;
            div_cnt_r <= '0;
            count_r   <= '0;
            reject_r  <= 1'b0;
            bad_r     <= bad_geom;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r     <= div_ge ? WIDTH_W'(rem_sh - {1'b0, width_r})
                              : rem_sh[WIDTH_W-1:0];
          div_r     <= {div_r[ADDR_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + DCNT_W'(1);
          if (div_cnt_r == DIV_LAST) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // row >= height is the same as match_index >= width * height
          if (bad_r || (div_r >= ADDR_W'(height_r))) begin
            reject_r <= 1'b1;
            state_r  <= ST_DONE;
          end else begin
            row_addr_r <= start_addr;
            addr_r     <= start_addr;
            dx_r       <= half_neg;
            dy_r       <= half_neg;
            state_r    <= ST_CREAD;
          end
        end
        ST_CREAD: begin
          state_r <= ST_CLATCH;
        end
        ST_CLATCH: begin
          centre_r <= mem_q_r;
          state_r  <= ST_WALK;
        end
        ST_WALK: begin
          if (last_px) begin
            state_r <= ST_DRAIN;
          end else if (dx_r == half_pos) begin
            dx_r       <= half_neg;
            dy_r       <= dy_r + DOFF_W'(1);
            row_addr_r <= row_addr_r + $signed(AS_W'(width_r));
            addr_r     <= row_addr_r + $signed(AS_W'(width_r));
          end else begin
            dx_r   <= dx_r + DOFF_W'(1);
            addr_r <= addr_r + AS_W'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_qi_r    <= qi_r;
            out_mi_r    <= mi_r;
            out_count_r <= reject_r ? '0 : count_r;
            out_kept_r  <= !reject_r && (count_r < limit_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.query_index_out = out_qi_r;
  assign out_if.match_index_out = out_mi_r;
  assign out_if.kept            = out_kept_r;
  assign out_if.boundary_count  = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= COUNT_W'(MAX_WINDOW * MAX_WINDOW)))
    else $error("boundary count beyond window area");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= DIV_LAST))
    else $error("divider ran past its last step");

  a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ($past(state_r) == ST_WALK))
    else $error("window read pending outside the walk");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result word appeared without a finished query");

endmodule

`default_nettype wire
